// ===== rtl/fnvh_pkg.sv =====
// Package with the shared constants and types of the image content hash block.
package fnvh_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned DimW  = 14;
  localparam int unsigned ApbAw = 3;
  localparam int unsigned ApbDw = 32;

  // The FNV prime is 2^40 + 0x1b3, so one mix is a shift plus a narrow product.
  localparam int unsigned PrimeShift = 40;
  localparam int unsigned PrimeLoW   = 9;
  localparam logic [PrimeLoW-1:0] PrimeLo = 9'h1b3;

  localparam logic [HashW-1:0] FnvOffset = 64'hcbf29ce484222325;
  localparam logic [HashW-1:0] HashOne   = 64'h1;

  localparam logic [DimW-1:0] DimReset = 14'd1;

  // Register indexes, taken from paddr[2].
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } fnvh_dims_t;

endpackage

// ===== rtl/fnvh_mix_unit.sv =====
// Shared FNV-1a mixing step: XOR one byte into the hash and multiply by the prime.
module fnvh_mix_unit (
  input  logic [fnvh_pkg::HashW-1:0] hash_i,
  input  logic [fnvh_pkg::ByteW-1:0] byte_i,
  output logic [fnvh_pkg::HashW-1:0] hash_o
);

  localparam int unsigned ProdW = fnvh_pkg::HashW + fnvh_pkg::PrimeLoW;

  logic [fnvh_pkg::HashW-1:0] mixed;
  logic [ProdW-1:0]           prod_lo;

  assign mixed   = hash_i ^ {{(fnvh_pkg::HashW-fnvh_pkg::ByteW){1'b0}}, byte_i};
  assign prod_lo = ProdW'(mixed) * ProdW'(fnvh_pkg::PrimeLo);
  assign hash_o  = (mixed << fnvh_pkg::PrimeShift) + prod_lo[fnvh_pkg::HashW-1:0];

endmodule

// ===== rtl/fnvh_cfg_regs.sv =====
// APB register file holding the image width and height.
module fnvh_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fnvh_pkg::ApbAw-1:0] paddr,
  input  logic [fnvh_pkg::ApbDw-1:0] pwdata,
  output logic [fnvh_pkg::ApbDw-1:0] prdata,
  output logic                       pready,
  output fnvh_pkg::fnvh_dims_t       dims_o
);

  logic [fnvh_pkg::DimW-1:0] width_q, width_d;
  logic [fnvh_pkg::DimW-1:0] height_q, height_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (paddr[2])
        fnvh_pkg::RegWidth:  width_d  = pwdata[fnvh_pkg::DimW-1:0];
        fnvh_pkg::RegHeight: height_d = pwdata[fnvh_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fnvh_pkg::DimReset;
      height_q <= fnvh_pkg::DimReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      fnvh_pkg::RegWidth:  prdata = {{(fnvh_pkg::ApbDw-fnvh_pkg::DimW){1'b0}}, width_q};
      fnvh_pkg::RegHeight: prdata = {{(fnvh_pkg::ApbDw-fnvh_pkg::DimW){1'b0}}, height_q};
      default:             prdata = '0;
    endcase
  end

  assign dims_o.width  = width_q;
  assign dims_o.height = height_q;

endmodule

// ===== rtl/image_content_fnv1a_hash_top.sv =====
// Top level of the image content hash: sequencer around one shared FNV-1a mix unit.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   input   | in        | in_valid_i / in_stall_o | pixel_byte_i, last_byte_i
//   output  | out       | out_valid_o/out_stall_i | image_hash_o
//   config  | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// Inside a frame each byte is mixed in its accepting cycle; one byte per cycle when not stalled.
// For the first byte of a frame, its accepting cycle seeds the hash, then
// the single mix unit folds in the eight dimension bytes and the pixel byte, one per
// cycle, while the input stalls.
// Reset clears the frame flag and the sequencer; the dimension registers reset to one.
// Input also stalls while a finished hash waits under output stall.
module image_content_fnv1a_hash_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [fnvh_pkg::ByteW-1:0] pixel_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fnvh_pkg::HashW-1:0] image_hash_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fnvh_pkg::ApbAw-1:0] paddr,
  input  logic [fnvh_pkg::ApbDw-1:0] pwdata,
  output logic [fnvh_pkg::ApbDw-1:0] prdata,
  output logic                       pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIM  = 2'd1;
  localparam logic [1:0] ST_PIX  = 2'd2;

  localparam logic [2:0] DimLast = 3'd7;

  fnvh_pkg::fnvh_dims_t dims;

  logic [1:0]                 state_q, state_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       in_frame_q, in_frame_d;
  logic [fnvh_pkg::HashW-1:0] hash_q, hash_d;
  logic [fnvh_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [fnvh_pkg::HashW-1:0] out_hash_q, out_hash_d;

  logic [fnvh_pkg::ByteW-1:0] mix_byte;
  logic [fnvh_pkg::HashW-1:0] mix_hash;
  logic [fnvh_pkg::DimW-1:0]  dim_word;
  logic [fnvh_pkg::ByteW-1:0] dim_byte;
  logic                       in_accept;
  logic                       out_load;

  fnvh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  // Width bytes first, then height; the upper two bytes of each are always zero.
  assign dim_word = cnt_q[2] ? dims.height : dims.width;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    dim_byte = dim_word[fnvh_pkg::ByteW-1:0];
      2'd1:    dim_byte = {{(2*fnvh_pkg::ByteW-fnvh_pkg::DimW){1'b0}},
                           dim_word[fnvh_pkg::DimW-1:fnvh_pkg::ByteW]};
      default: dim_byte = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_DIM:  mix_byte = dim_byte;
      ST_PIX:  mix_byte = byte_q;
      default: mix_byte = pixel_byte_i;
    endcase
  end

  fnvh_mix_unit u_mix (
    .hash_i (hash_q),
    .byte_i (mix_byte),
    .hash_o (mix_hash)
  );

  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_frame_d = in_frame_q;
    hash_d     = hash_q;
    byte_d     = byte_q;
    last_d     = last_q;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_frame_q) begin
            hash_d = mix_hash;
            if (last_byte_i) begin
              out_load   = 1'b1;
              in_frame_d = 1'b0;
            end
          end else begin
            // Frame start: seed the hash and hold the byte until the dimensions are in.
            hash_d  = fnvh_pkg::FnvOffset;
            byte_d  = pixel_byte_i;
            last_d  = last_byte_i;
            cnt_d   = '0;
            state_d = ST_DIM;
          end
        end
      end
      ST_DIM: begin
        hash_d = mix_hash;
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == DimLast) begin
          state_d = ST_PIX;
        end
      end
      ST_PIX: begin
        hash_d     = mix_hash;
        state_d    = ST_IDLE;
        out_load   = last_q;
        in_frame_d = ~last_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_hash_d  = out_hash_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_hash_d  = (mix_hash == '0) ? fnvh_pkg::HashOne : mix_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_frame_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      in_frame_q  <= in_frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q     <= hash_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    out_hash_q <= out_hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign image_hash_o = out_hash_q;

`ifndef SYNTHESIS
  a_dim_to_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIM && cnt_q == DimLast) |=> (state_q == ST_PIX))
    else $error("dimension sweep did not hand over to the pixel byte");

  a_pix_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |=> (state_q == ST_IDLE && in_frame_q == !$past(last_q)))
    else $error("frame flag wrong after the first byte of a frame");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q == ST_PIX && last_q) ||
                            $past(in_accept && last_byte_i && in_frame_q)))
    else $error("result appeared without a request marked last");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the FNV-1a image content hash block.
`timescale 1ns / 1ps

class fnv_frame_tracker;
  localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01b3;

  logic [63:0] running;
  bit          in_frame;
  logic [13:0] width;
  logic [13:0] height;
  logic [63:0] pending[$];
  int unsigned fail_count;

  function new();
    running    = '0;
    in_frame   = 1'b0;
    width      = fnvh_pkg::DimReset;
    height     = fnvh_pkg::DimReset;
    fail_count = 0;
  endfunction

  function logic [63:0] mix(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x * FnvPrime;
  endfunction

  // A dimension enters the hash as four little-endian bytes of a 32-bit word.
  function logic [63:0] mix_dim(logic [63:0] h, logic [13:0] d);
    logic [31:0] word;
    logic [63:0] acc;
    word = {18'd0, d};
    acc  = h;
    for (int k = 0; k < 4; k++) begin
      acc = mix(acc, word[8*k +: 8]);
    end
    return acc;
  endfunction

  function void set_dim(logic idx, logic [31:0] value);
    if (idx == fnvh_pkg::RegWidth) begin
      width = value[13:0];
    end else begin
      height = value[13:0];
    end
  endfunction

  function logic [13:0] dim(logic idx);
    return (idx == fnvh_pkg::RegWidth) ? width : height;
  endfunction

  function void take_byte(logic [7:0] b, logic last);
    logic [63:0] h;
    h = running;
    if (!in_frame) begin
      h = mix_dim(mix_dim(fnvh_pkg::FnvOffset, width), height);
    end
    h       = mix(h, b);
    running = h;
    if (last) begin
      in_frame = 1'b0;
      pending.push_back((h == '0) ? fnvh_pkg::HashOne : h);
    end else begin
      in_frame = 1'b1;
    end
  endfunction

  function void note_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
    end
  endfunction

  function void check_hash(logic [63:0] act_val);
    logic [63:0] exp_val;
    if (pending.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("image hash %h arrived with no frame pending", act_val);
      end
    end else begin
      exp_val = pending.pop_front();
      if (exp_val !== act_val) begin
        note_mismatch("image_hash", exp_val, act_val);
      end
    end
  endfunction
endclass

module tb;

  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomItems  = 324;
  localparam int unsigned NumPhases    = 6;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [fnvh_pkg::ByteW-1:0] pixel_byte = '0;
  logic                       last_byte  = 1'b0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic [fnvh_pkg::HashW-1:0] image_hash;
  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [fnvh_pkg::ApbAw-1:0] paddr      = '0;
  logic [fnvh_pkg::ApbDw-1:0] pwdata     = '0;
  logic [fnvh_pkg::ApbDw-1:0] prdata;
  logic                       pready;

  fnv_frame_tracker tracker = new();
  bit               hold_req  = 1'b0;
  int unsigned      items_sent = 0;

  image_content_fnv1a_hash_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_byte_i (pixel_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .image_hash_o (image_hash),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    pixel_byte <= b;
    last_byte  <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    tracker.take_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame(int unsigned len, bit steady);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1, steady ? 0 : pick_gap());
    end
  endtask

  // The block may still be folding in a first byte that produces no hash yet,
  // so a settle wait of SettleCycles follows once nothing is pending.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [31:0] value,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_dim(logic idx);
    logic [31:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== {18'd0, tracker.dim(idx)}) begin
      tracker.note_mismatch(idx == fnvh_pkg::RegWidth ? "image_width readback"
                                                      : "image_height readback",
                            {50'd0, tracker.dim(idx)}, {32'd0, rdata});
    end
  endtask

  task automatic write_dim(logic idx, logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    tracker.set_dim(idx, value);
    check_dim(idx);
  endtask

  task automatic set_dims(logic [31:0] w, logic [31:0] h);
    drain();
    write_dim(fnvh_pkg::RegWidth, w);
    write_dim(fnvh_pkg::RegHeight, h);
  endtask

  // Sink side: stretches of no stall, short stalls, an occasional long one,
  // and one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int unsigned mode;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end else if (mode < 9) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      tracker.check_hash(image_hash);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_end;
    int          nominal;
    int          len;
    int unsigned r;
    logic [31:0] wv;
    logic [31:0] hv;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_dim(fnvh_pkg::RegWidth);
    check_dim(fnvh_pkg::RegHeight);

    // Default 1x1 image: one-byte frames at both byte extremes, then a full pixel.
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hff, 1'b1, 0);
    send_byte(8'h00, 1'b0, 0);
    send_byte(8'hff, 1'b0, 1);
    send_byte(8'ha5, 1'b1, 0);

    // Every write data bit set; only the low 14 bits survive.
    set_dims(32'hffff_ffff, 32'hffff_ffff);
    send_byte(8'h5a, 1'b0, 0);
    send_byte(8'hc3, 1'b1, 2);

    // Dimensions of zero are mixed as given.
    set_dims(32'h0000_0000, 32'h0000_0000);
    send_byte(8'h80, 1'b1, 0);
    send_byte(8'h01, 1'b0, 0);
    send_byte(8'h02, 1'b0, 0);
    send_byte(8'h04, 1'b1, 0);

    // A width change inside a frame only takes effect at the next frame.
    set_dims(32'h5555_4002, 32'haaaa_8003);
    send_byte(8'h10, 1'b0, 0);
    drain();
    write_dim(fnvh_pkg::RegWidth, 32'h0000_0005);
    send_byte(8'h20, 1'b0, 0);
    send_byte(8'h40, 1'b1, 0);
    send_byte(8'h7f, 1'b1, 0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin wv = 32'd1; hv = 32'd1; end
        1: begin wv = $urandom_range(1, 4); hv = $urandom_range(1, 4); end
        2: begin wv = 32'd16383; hv = 32'd1; end
        3: begin wv = $urandom_range(1, 3); hv = $urandom_range(1, 3); end
        4: begin wv = 32'd0; hv = 32'd16383; end
        default: begin wv = $urandom_range(0, 16383); hv = $urandom_range(0, 16383); end
      endcase
      wv = ($urandom() & 32'hffff_c000) | wv;
      hv = ($urandom() & 32'hffff_c000) | hv;
      set_dims(wv, hv);

      if (ph == 1) begin
        // Keep offering short frames while the sink holds off, so the block backs up.
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
          send_frame($urandom_range(1, 2), 1'b1);
        end
      end

      phase_end = items_sent + RandomItems / NumPhases;
      while (items_sent < phase_end) begin
        nominal = int'(tracker.width) * int'(tracker.height) * 3;
        r = $urandom_range(0, 99);
        if (nominal != 0 && nominal <= 60 && r < 65) begin
          len = nominal;
        end else if (nominal != 0 && nominal <= 60 && r < 77) begin
          len = ($urandom_range(0, 1) == 1 || nominal == 1) ? nominal + 1 : nominal - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          len = 1;
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(7, 24);
        end else begin
          len = $urandom_range(1, 6);
        end
        send_frame(len, $urandom_range(0, 3) == 0);

        if (ph == 3 && items_sent >= phase_end - RandomItems / (2 * NumPhases)
            && items_sent < phase_end - RandomItems / (2 * NumPhases) + len) begin
          in_valid <= 1'b0;
          while (tracker.pending.size() != 0) @(posedge clk_i);
        end
      end
    end

    drain();
    if (tracker.fail_count == 0 && tracker.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fnvh_pkg.sv
rtl/fnvh_mix_unit.sv
rtl/fnvh_cfg_regs.sv
rtl/image_content_fnv1a_hash_top.sv
bench/tb.sv
